FILE: hdl/ust_pkg.sv
package ust_pkg;

   // command codes on req_cmd
   typedef enum logic [1:0] {
      CMD_ADD        = 2'd0,
      CMD_RMV_VALUE  = 2'd1,
      CMD_RMV_INDEX  = 2'd2,
      CMD_RMV_ALL    = 2'd3
   } cmd_type;

   // result status codes on rsp_status
   typedef enum logic [1:0] {
      STATUS_OK        = 2'd0,
      STATUS_FULL      = 2'd1,
      STATUS_NOT_FOUND = 2'd2,
      STATUS_BAD_INDEX = 2'd3
   } status_type;

   // sequencer states
   typedef enum logic [2:0] {
      S_IDLE,
      S_EXEC,
      S_SCAN,
      S_TAKE,
      S_LAST,
      S_RESP,
      S_ALL
   } state_type;

endpackage

FILE: hdl/unordered_swap_remove_table.sv
// States from acceptance to rsp_valid: add S_EXEC, S_RESP; remove at index S_EXEC, S_TAKE,
// S_LAST, S_RESP; remove by value S_EXEC, S_SCAN over the entries, S_LAST on a hit, S_RESP;
// remove all S_EXEC, then one word per cycle from S_ALL while the output register is free.
// One command at a time; the next is taken once the last word is in the output register.
// The rate is set by the single read port of the entry RAM: at most one entry read per cycle.
// Reset (synchronous, active high) clears the count, sequencer and output valid; no RAM clear.
module unordered_swap_remove_table
   import ust_pkg::*;
   #(parameter int CAPACITY   = 32,
     parameter int VALUE_BITS = 32)
   (
   input  logic        clock,
   input  logic        reset,
   // command channel
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_cmd,
   input  logic [31:0] req_value,
   input  logic [4:0]  req_position,
   input  logic        req_release_req,
   // result channel
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_status,
   output logic        rsp_freed_valid,
   output logic [31:0] rsp_freed_value,
   output logic [5:0]  rsp_entry_count,
   output logic        rsp_last
   );

   localparam int AW = $clog2(CAPACITY);      // entry address width
   localparam int CW = $clog2(CAPACITY + 1);  // count width, holds CAPACITY itself
   localparam logic [CW-1:0] CAP_CNT = CW'(CAPACITY);
   localparam logic [CW-1:0] CNT_ONE = CW'(1);

   // sequencer
   state_type state_ff, state_in;

   // latched command word
   cmd_type                cmd_ff, cmd_in;
   logic [VALUE_BITS-1:0]  val_ff, val_in;
   logic [4:0]             pos_ff, pos_in;
   logic                   rel_ff, rel_in;

   // table state and work registers
   logic [CW-1:0]          count_ff, count_in;
   logic [AW-1:0]          scan_ff, scan_in;
   logic [AW-1:0]          hole_ff, hole_in;
   logic [VALUE_BITS-1:0]  freed_ff, freed_in;
   status_type             status_ff, status_in;
   logic                   fv_ff, fv_in;

   // output register
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [1:0]             rsp_status_ff, rsp_status_in;
   logic                   rsp_freed_valid_ff, rsp_freed_valid_in;
   logic [31:0]            rsp_freed_value_ff, rsp_freed_value_in;
   logic [5:0]             rsp_entry_count_ff, rsp_entry_count_in;
   logic                   rsp_last_ff, rsp_last_in;
   logic                   rsp_load;
   logic                   out_free;

   // entry RAM
   logic                   ram_wr_en;
   logic [AW-1:0]          ram_wr_addr;
   logic [VALUE_BITS-1:0]  ram_wr_data;
   logic                   ram_rd_en;
   logic [AW-1:0]          ram_rd_addr;
   logic [VALUE_BITS-1:0]  ram_rd_data;

   // helpers
   logic                   req_accept;
   logic [VALUE_BITS+31:0] val_wide;
   logic [CW+4:0]          pos_wide;
   logic [CW+4:0]          cnt_wide;
   logic                   bad_index;
   logic                   hit;
   logic                   more_to_scan;
   logic [CW-1:0]          cnt_dec;
   logic [CW-1:0]          scan_nxt;
   logic [AW-1:0]          last_addr;
   logic [VALUE_BITS+31:0] freed_wide;
   logic [VALUE_BITS+31:0] rd_wide;
   logic [CW+5:0]          cnt_out_wide;
   logic [CW+5:0]          dec_out_wide;

   ust_ram #(
      .WIDTH (VALUE_BITS),
      .DEPTH (CAPACITY)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   assign req_stall  = (state_ff != S_IDLE);
   assign req_accept = req_valid && !req_stall;
   assign out_free   = !rsp_valid_ff || !rsp_stall;

   // value taken modulo 2^VALUE_BITS, zero extended when wider
   assign val_wide     = {{VALUE_BITS{1'b0}}, req_value};
   assign pos_wide     = {{CW{1'b0}}, pos_ff};
   assign cnt_wide     = {5'b0, count_ff};
   assign bad_index    = (pos_wide >= cnt_wide);
   assign hit          = (ram_rd_data == val_ff);
   assign cnt_dec      = count_ff - CNT_ONE;
   assign scan_nxt     = CW'(scan_ff) + CNT_ONE;
   assign more_to_scan = (scan_nxt < count_ff);
   assign last_addr    = cnt_dec[AW-1:0];
   assign freed_wide   = {32'b0, freed_ff};
   assign rd_wide      = {32'b0, ram_rd_data};
   assign cnt_out_wide = {6'b0, count_ff};
   assign dec_out_wide = {6'b0, cnt_dec};

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_accept) begin
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            case (cmd_ff)
               CMD_ADD:       state_in = S_RESP;
               CMD_RMV_VALUE: state_in = (count_ff == '0) ? S_RESP : S_SCAN;
               CMD_RMV_INDEX: state_in = bad_index ? S_RESP : S_TAKE;
               CMD_RMV_ALL:   state_in = (!rel_ff || count_ff == '0) ? S_RESP : S_ALL;
               default:       state_in = S_RESP;
            endcase
         end
         S_SCAN: begin
            if (hit) begin
               state_in = S_LAST;
            end else if (!more_to_scan) begin
               state_in = S_RESP;
            end
         end
         S_TAKE: state_in = S_LAST;
         S_LAST: state_in = S_RESP;
         S_RESP: begin
            if (out_free) begin
               state_in = S_IDLE;
            end
         end
         S_ALL: begin
            if (out_free && count_ff == CNT_ONE) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // datapath control
   always_comb begin
      cmd_in      = cmd_ff;
      val_in      = val_ff;
      pos_in      = pos_ff;
      rel_in      = rel_ff;
      count_in    = count_ff;
      scan_in     = scan_ff;
      hole_in     = hole_ff;
      freed_in    = freed_ff;
      status_in   = status_ff;
      fv_in       = fv_ff;
      ram_wr_en   = 1'b0;
      ram_wr_addr = count_ff[AW-1:0];
      ram_wr_data = val_ff;
      ram_rd_en   = 1'b0;
      ram_rd_addr = '0;
      rsp_load    = 1'b0;
      rsp_status_in      = rsp_status_ff;
      rsp_freed_valid_in = rsp_freed_valid_ff;
      rsp_freed_value_in = rsp_freed_value_ff;
      rsp_entry_count_in = rsp_entry_count_ff;
      rsp_last_in        = rsp_last_ff;

      case (state_ff)
         S_IDLE: begin
            if (req_accept) begin
               cmd_in = cmd_type'(req_cmd);
               val_in = val_wide[VALUE_BITS-1:0];
               pos_in = req_position;
               rel_in = req_release_req;
            end
         end
         S_EXEC: begin
            status_in = STATUS_OK;
            fv_in     = 1'b0;
            case (cmd_ff)
               CMD_ADD: begin
                  if (count_ff >= CAP_CNT) begin
                     status_in = STATUS_FULL;
                  end else begin
                     ram_wr_en = 1'b1;
                     count_in  = count_ff + CNT_ONE;
                  end
               end
               CMD_RMV_VALUE: begin
                  if (count_ff == '0) begin
                     status_in = STATUS_NOT_FOUND;
                  end else begin
                     ram_rd_en   = 1'b1;
                     ram_rd_addr = '0;
                     scan_in     = '0;
                  end
               end
               CMD_RMV_INDEX: begin
                  if (bad_index) begin
                     status_in = STATUS_BAD_INDEX;
                  end else begin
                     ram_rd_en   = 1'b1;
                     ram_rd_addr = pos_wide[AW-1:0];
                     hole_in     = pos_wide[AW-1:0];
                  end
               end
               CMD_RMV_ALL: begin
                  if (!rel_ff || count_ff == '0) begin
                     count_in = '0;
                  end else begin
                     // first word is position 0, then the tail moves down one by one
                     ram_rd_en   = 1'b1;
                     ram_rd_addr = '0;
                  end
               end
               default: status_in = STATUS_OK;
            endcase
         end
         S_SCAN: begin
            if (hit) begin
               freed_in    = ram_rd_data;
               hole_in     = scan_ff;
               ram_rd_en   = 1'b1;
               ram_rd_addr = last_addr;
            end else if (more_to_scan) begin
               ram_rd_en   = 1'b1;
               ram_rd_addr = scan_nxt[AW-1:0];
               scan_in     = scan_nxt[AW-1:0];
            end else begin
               status_in = STATUS_NOT_FOUND;
               fv_in     = 1'b0;
            end
         end
         S_TAKE: begin
            freed_in    = ram_rd_data;
            ram_rd_en   = 1'b1;
            ram_rd_addr = last_addr;
         end
         S_LAST: begin
            // last entry fills the hole; harmless when the hole is the last slot
            ram_wr_en   = 1'b1;
            ram_wr_addr = hole_ff;
            ram_wr_data = ram_rd_data;
            count_in    = cnt_dec;
            status_in   = STATUS_OK;
            fv_in       = rel_ff;
         end
         S_RESP: begin
            if (out_free) begin
               rsp_load           = 1'b1;
               rsp_status_in      = status_ff;
               rsp_freed_valid_in = fv_ff;
               rsp_freed_value_in = fv_ff ? freed_wide[31:0] : 32'b0;
               rsp_entry_count_in = cnt_out_wide[5:0];
               rsp_last_in        = 1'b1;
            end
         end
         S_ALL: begin
            if (out_free) begin
               rsp_load           = 1'b1;
               rsp_status_in      = STATUS_OK;
               rsp_freed_valid_in = 1'b1;
               rsp_freed_value_in = rd_wide[31:0];
               rsp_entry_count_in = dec_out_wide[5:0];
               rsp_last_in        = (count_ff == CNT_ONE);
               count_in           = cnt_dec;
               if (count_ff != CNT_ONE) begin
                  ram_rd_en   = 1'b1;
                  ram_rd_addr = last_addr;
               end
            end
         end
         default: status_in = status_ff;
      endcase
   end

   assign rsp_valid_in = rsp_load || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff             <= cmd_in;
      val_ff             <= val_in;
      pos_ff             <= pos_in;
      rel_ff             <= rel_in;
      scan_ff            <= scan_in;
      hole_ff            <= hole_in;
      freed_ff           <= freed_in;
      status_ff          <= status_in;
      fv_ff              <= fv_in;
      rsp_status_ff      <= rsp_status_in;
      rsp_freed_valid_ff <= rsp_freed_valid_in;
      rsp_freed_value_ff <= rsp_freed_value_in;
      rsp_entry_count_ff <= rsp_entry_count_in;
      rsp_last_ff        <= rsp_last_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_freed_valid = rsp_freed_valid_ff;
   assign rsp_freed_value = rsp_freed_value_ff;
   assign rsp_entry_count = rsp_entry_count_ff;
   assign rsp_last        = rsp_last_ff;

   // count stays within the table
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CAP_CNT)
      else $error("entry count above capacity");

   // single RAM port pair is never read and written in the same cycle
   a_no_rw_overlap: assert property (@(posedge clock) disable iff (reset)
      !(ram_wr_en && ram_rd_en))
      else $error("RAM read and write in the same cycle");

   // a finished command returns the sequencer to idle
   a_last_to_idle: assert property (@(posedge clock) disable iff (reset)
      (rsp_load && rsp_last_in) |=> (state_ff == S_IDLE))
      else $error("last word loaded but sequencer not idle");

   // remove all leaves an empty table after its final word
   a_all_empties: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_ALL && rsp_load && rsp_last_in) |=> (count_ff == '0))
      else $error("remove all left entries behind");

   // the output register only loads when the slot is free
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_stall) |-> !rsp_load)
      else $error("stalled response overwritten");

endmodule

FILE: hdl/ust_ram.sv
module ust_ram
   #(parameter int WIDTH = 32,
     parameter int DEPTH = 32)
   (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
   );

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      // read data holds until the next read
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: tb/ust_checker.sv
`timescale 1ns / 100ps
module ust_checker
   import ust_pkg::*;
   #(parameter int CAPACITY = 32)
   (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_stall,
   input  logic [1:0]  req_cmd,
   input  logic [31:0] req_value,
   input  logic [4:0]  req_position,
   input  logic        req_release_req,
   input  logic        rsp_valid,
   input  logic        rsp_stall,
   input  logic [1:0]  rsp_status,
   input  logic        rsp_freed_valid,
   input  logic [31:0] rsp_freed_value,
   input  logic [5:0]  rsp_entry_count,
   input  logic        rsp_last,
   output int          fail_count,
   output int          pending
   );

   typedef struct {
      status_type  status;
      logic        freed_valid;
      logic [31:0] freed_value;
      logic [5:0]  entry_count;
      logic        last;
   } rsp_word_type;

   // shadow table; counters start at zero
   logic [31:0]  tbl_entries [CAPACITY];
   int           tbl_count;
   rsp_word_type rsp_expected_q [$];
   int           mismatches;

   task automatic report_mismatch(string msg);
      $display("%0t: mismatch: %s", $realtime, msg);
      mismatches++;
   endtask

   function automatic void push_rsp(status_type status, logic freed_valid,
                                    logic [31:0] freed_value, logic last);
      rsp_word_type w;
      w.status      = status;
      w.freed_valid = freed_valid;
      w.freed_value = freed_valid ? freed_value : 32'd0;
      w.entry_count = 6'(tbl_count);
      w.last        = last;
      rsp_expected_q.push_back(w);
   endfunction

   // drop an entry, fill the hole with the last one
   function automatic logic [31:0] take_entry(int idx);
      logic [31:0] v;
      v = tbl_entries[idx];
      tbl_count--;
      if (tbl_count != 0) tbl_entries[idx] = tbl_entries[tbl_count];
      return v;
   endfunction

   function automatic void predict_command(cmd_type cmd, logic [31:0] value,
                                           logic [4:0] position, logic rel);
      int          hit;
      logic [31:0] v;
      hit = -1;
      case (cmd)
         CMD_ADD: begin
            if (tbl_count >= CAPACITY) begin
               push_rsp(STATUS_FULL, 1'b0, 32'd0, 1'b1);
            end else begin
               tbl_entries[tbl_count] = value;
               tbl_count++;
               push_rsp(STATUS_OK, 1'b0, 32'd0, 1'b1);
            end
         end
         CMD_RMV_VALUE: begin
            for (int i = 0; i < tbl_count; i++)
               if (hit < 0 && tbl_entries[i] == value) hit = i;
            if (hit < 0) begin
               push_rsp(STATUS_NOT_FOUND, 1'b0, 32'd0, 1'b1);
            end else begin
               v = take_entry(hit);
               push_rsp(STATUS_OK, rel, v, 1'b1);
            end
         end
         CMD_RMV_INDEX: begin
            if (int'(position) >= tbl_count) begin
               push_rsp(STATUS_BAD_INDEX, 1'b0, 32'd0, 1'b1);
            end else begin
               v = take_entry(int'(position));
               push_rsp(STATUS_OK, rel, v, 1'b1);
            end
         end
         CMD_RMV_ALL: begin
            if (!rel || tbl_count == 0) begin
               tbl_count = 0;
               push_rsp(STATUS_OK, 1'b0, 32'd0, 1'b1);
            end else begin
               while (tbl_count != 0) begin
                  v = take_entry(0);
                  push_rsp(STATUS_OK, 1'b1, v, tbl_count == 0);
               end
            end
         end
      endcase
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         tbl_count = 0;
         rsp_expected_q.delete();
      end else begin
         // results first: a word taken at this edge belongs to an older command
         if (rsp_valid && !rsp_stall) begin
            if (rsp_expected_q.size() == 0) begin
               report_mismatch($sformatf("unexpected result word, status %0d", rsp_status));
            end else begin
               rsp_word_type w;
               w = rsp_expected_q.pop_front();
               if (rsp_status !== w.status)
                  report_mismatch($sformatf("status got %0d want %0d", rsp_status, w.status));
               if (rsp_freed_valid !== w.freed_valid)
                  report_mismatch($sformatf("freed_valid got %b want %b",
                                            rsp_freed_valid, w.freed_valid));
               if (rsp_freed_value !== w.freed_value)
                  report_mismatch($sformatf("freed_value got %h want %h",
                                            rsp_freed_value, w.freed_value));
               if (rsp_entry_count !== w.entry_count)
                  report_mismatch($sformatf("entry_count got %0d want %0d",
                                            rsp_entry_count, w.entry_count));
               if (rsp_last !== w.last)
                  report_mismatch($sformatf("last got %b want %b", rsp_last, w.last));
            end
         end
         if (req_valid && !req_stall)
            predict_command(cmd_type'(req_cmd), req_value, req_position, req_release_req);
      end
      fail_count <= mismatches;
      pending    <= rsp_expected_q.size();
   end

endmodule

FILE: tb/unordered_swap_remove_table_tb.sv
`timescale 1ns / 100ps
module unordered_swap_remove_table_tb;
   import ust_pkg::*;

   // Slowest run: ~125 commands, remove all up to 32 words each, receiver
   // stalling about half the time, plus one long hold. Well under this.
   localparam int LIMIT        = 200000;
   // remove all sends its first word after S_EXEC, then one per cycle while not stalled
   localparam int DRAIN_CYCLES = 40;
   localparam int HOLD_CYCLES  = 300;
   localparam int PHASE_ITEMS  = 12;

   logic        clock           = 1'b0;
   logic        reset           = 1'b1;
   logic        req_valid       = 1'b0;
   logic        req_stall;
   logic [1:0]  req_cmd         = CMD_ADD;
   logic [31:0] req_value       = 32'd0;
   logic [4:0]  req_position    = 5'd0;
   logic        req_release_req = 1'b0;
   logic        rsp_valid;
   logic        rsp_stall       = 1'b0;
   logic [1:0]  rsp_status;
   logic        rsp_freed_valid;
   logic [31:0] rsp_freed_value;
   logic [5:0]  rsp_entry_count;
   logic        rsp_last;

   int   fail_count;
   int   pending;
   int   cycle_count = 0;
   int   idle_pct    = 0;   // sender idle chance, percent
   int   stall_pct   = 0;   // receiver stall chance, percent
   logic pressure_go = 1'b0;
   logic hold_on     = 1'b0;

   // values that repeat often, so remove by value finds hits and duplicates
   logic [31:0] value_pool [8] = '{32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0001,
                                   32'h8000_0000, 32'h0000_0007, 32'h1234_5678,
                                   32'h0000_00FF, 32'h0000_002A};

   always #5 clock = ~clock;

   unordered_swap_remove_table i_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_cmd         (req_cmd),
      .req_value       (req_value),
      .req_position    (req_position),
      .req_release_req (req_release_req),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_status      (rsp_status),
      .rsp_freed_valid (rsp_freed_valid),
      .rsp_freed_value (rsp_freed_value),
      .rsp_entry_count (rsp_entry_count),
      .rsp_last        (rsp_last)
   );

   ust_checker i_checker (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_cmd         (req_cmd),
      .req_value       (req_value),
      .req_position    (req_position),
      .req_release_req (req_release_req),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_status      (rsp_status),
      .rsp_freed_valid (rsp_freed_valid),
      .rsp_freed_value (rsp_freed_value),
      .rsp_entry_count (rsp_entry_count),
      .rsp_last        (rsp_last),
      .fail_count      (fail_count),
      .pending         (pending)
   );

   // receiver: random stall, forced high during the long hold
   always @(posedge clock) begin
      if (hold_on) begin
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(0, 99) < stall_pct);
      end
   end

   // long hold-off: once triggered, the receiver refuses words for
   // HOLD_CYCLES while the sender keeps offering, so the block backs up
   initial begin
      int held;
      do @(posedge clock); while (!pressure_go);
      hold_on <= 1'b1;
      for (held = 0; held < HOLD_CYCLES; held++) @(posedge clock);
      hold_on <= 1'b0;
   end

   // watchdog
   initial begin
      while (cycle_count < LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("[FAIL] regression broken");
      $finish;
   end

   // half the time a pool value, else a full random word
   function automatic logic [31:0] pick_value();
      if ($urandom_range(0, 1) == 0) return value_pool[$urandom_range(0, 7)];
      return $urandom();
   endfunction

   // Offer one command word and hold it until the block takes it. Idle
   // cycles go before the word, so valid never drops once raised.
   task automatic send_word(cmd_type cmd, logic [31:0] value, logic [4:0] position,
                            logic rel);
      while ($urandom_range(0, 99) < idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_cmd         <= cmd;
      req_value       <= value;
      req_position    <= position;
      req_release_req <= rel;
      do @(posedge clock); while (req_stall);
   endtask

   task automatic send_adds(int n);
      for (int k = 0; k < n; k++)
         send_word(CMD_ADD, pick_value(), 5'($urandom), 1'($urandom));
   endtask

   initial begin
      int n;
      int r;
      int burst;

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // ---- directed ----
      // everything on an empty table: remove all still gives one word
      send_word(CMD_RMV_ALL,   32'd0, 5'd0, 1'b1);
      send_word(CMD_RMV_VALUE, 32'd0, 5'd0, 1'b1);
      send_word(CMD_RMV_INDEX, 32'd0, 5'd0, 1'b1);
      // value extremes
      send_word(CMD_ADD, 32'h0000_0000, 5'd31, 1'b0);
      send_word(CMD_ADD, 32'hFFFF_FFFF, 5'd0,  1'b1);
      send_word(CMD_ADD, 32'h1234_5678, 5'd0,  1'b0);
      send_word(CMD_ADD, 32'hA5A5_A5A5, 5'd0,  1'b0);
      // index out of range: top position, and exactly at the count
      send_word(CMD_RMV_INDEX, 32'd0, 5'd31, 1'b1);
      send_word(CMD_RMV_INDEX, 32'd0, 5'd4,  1'b1);
      // front removal moves the last entry into the hole
      send_word(CMD_RMV_INDEX, 32'd0, 5'd0,  1'b1);
      // removing the last position, without release
      send_word(CMD_RMV_INDEX, 32'hFFFF_FFFF, 5'd2, 1'b0);
      // miss, then hit by value
      send_word(CMD_RMV_VALUE, 32'hDEAD_BEEF, 5'd0, 1'b1);
      send_word(CMD_RMV_VALUE, 32'hA5A5_A5A5, 5'd0, 1'b1);
      // duplicates: the first one found goes
      send_word(CMD_ADD, 32'd5, 5'd0, 1'b0);
      send_word(CMD_ADD, 32'd5, 5'd0, 1'b0);
      send_word(CMD_RMV_VALUE, 32'd5, 5'd0, 1'b1);
      // remove all without release collapses to one word
      send_word(CMD_RMV_ALL, 32'd0, 5'd0, 1'b0);
      send_word(CMD_ADD, 32'd1, 5'd0, 1'b0);
      send_word(CMD_ADD, 32'd2, 5'd0, 1'b0);
      send_word(CMD_ADD, 32'd3, 5'd0, 1'b0);
      // remove all with release: one word per entry, last on the final one
      send_word(CMD_RMV_ALL, 32'd0, 5'd0, 1'b1);

      // ---- random, four idling phases ----
      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin idle_pct = 0;  stall_pct <= 0;  end
            1: begin idle_pct = 47; stall_pct <= 0;  end
            2: begin idle_pct = 0;  stall_pct <= 47; end
            default: begin idle_pct = 37; stall_pct <= 37; end
         endcase
         if (phase == 0) begin
            // fill past capacity so adds hit a full table, then drain it
            send_adds(34);
            send_word(CMD_RMV_ALL, 32'd0, 5'($urandom), 1'b1);
         end
         if (phase == 2) begin
            // long receiver hold while adds keep coming
            pressure_go <= 1'b1;
            send_adds(8);
         end
         n = 0;
         while (n < PHASE_ITEMS) begin
            r = $urandom_range(0, 99);
            if (r < 30) begin
               send_word(CMD_ADD, pick_value(), 5'($urandom), 1'($urandom));
            end else if (r < 50) begin
               send_word(CMD_RMV_VALUE, pick_value(), 5'($urandom), 1'($urandom));
            end else if (r < 70) begin
               send_word(CMD_RMV_INDEX, $urandom(), 5'($urandom_range(0, 31)),
                         1'($urandom));
            end else if (r < 78) begin
               send_word(CMD_RMV_ALL, $urandom(), 5'($urandom), 1'($urandom));
            end else begin
               // bursts of adds keep the table deep
               burst = $urandom_range(4, 12);
               send_adds(burst);
               n = n + burst - 1;
            end
            n++;
         end
      end
      req_valid <= 1'b0;

      // pending is a registered copy of the checker queue size, so wait for the next edge
      @(posedge clock);
      // wait out every expected word, then a quiet stretch for strays
      while (pending != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (fail_count == 0 && pending == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule

FILE: files.f
hdl/ust_pkg.sv
hdl/ust_ram.sv
hdl/unordered_swap_remove_table.sv
tb/ust_checker.sv
tb/unordered_swap_remove_table_tb.sv
